>>> hdl/abs_slip_controller_unit_assert.svh
// Assertion macros shared by the slip controller RTL.
`ifndef ABS_SLIP_CONTROLLER_UNIT_ASSERT_SVH
`define ABS_SLIP_CONTROLLER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ABS_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define ABS_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define ABS_CHK_NOW(lbl, ante, cons)
`define ABS_CHK_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/abs_pkg.sv
// Shared types and constants of the slip controller.
package abs_pkg;
  localparam int NW = 4;
  localparam int WI_W = 2;
  localparam int DIV_N = 32;
  localparam int DIV_D = 16;
  localparam int ACC_W = 36;
  // Raw acceleration at a one-millisecond tick is d * 10000 / 9, which is
  // d * 1111 plus d / 9. The ninth is a reciprocal multiply, exact for
  // magnitudes below 65536.
  localparam int ACC_WHOLE = 1111;
  localparam int RECIP9 = 58255;
  localparam int RECIP9_SH = 19;
  localparam logic [15:0] FULL_PRESSURE = 16'd32768;

  localparam logic [1:0] MODE_INACTIVE = 2'd0;
  localparam logic [1:0] MODE_MONITOR  = 2'd1;
  localparam logic [1:0] MODE_ACTIVE   = 2'd2;
  localparam logic [1:0] MODE_FAULT    = 2'd3;

  localparam logic [1:0] PH_NORMAL   = 2'd0;
  localparam logic [1:0] PH_REDUCE   = 2'd1;
  localparam logic [1:0] PH_HOLD     = 2'd2;
  localparam logic [1:0] PH_INCREASE = 2'd3;

  localparam logic [1:0] RND_NONE = 2'd0;
  localparam logic [1:0] RND_Q15  = 2'd1;
  localparam logic [1:0] RND_Q16  = 2'd2;

  localparam logic [3:0] REG_SLIP_THR  = 4'd0;
  localparam logic [3:0] REG_SLIP_TGT  = 4'd1;
  localparam logic [3:0] REG_RED_RATE  = 4'd2;
  localparam logic [3:0] REG_INC_RATE  = 4'd3;
  localparam logic [3:0] REG_MIN_SPEED = 4'd4;
  localparam logic [3:0] REG_REC_ACCEL = 4'd5;
  localparam logic [3:0] REG_MAX_SPEED = 4'd6;
  localparam logic [3:0] REG_EN_MASK   = 4'd7;

  typedef struct packed {
    logic       en;
    logic       clr;
    logic [1:0] rnd;
  } mac_ctl_t;
endpackage

>>> hdl/abs_div.sv
// Restoring divider, one quotient bit per cycle.
module abs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [abs_pkg::DIV_N-1:0]  dividend,
  input  logic [abs_pkg::DIV_D-1:0]  divisor,
  output logic [abs_pkg::DIV_N-1:0]  quotient,
  output logic                       busy,
  output logic                       done
);
  import abs_pkg::*;

  logic [DIV_D:0]   rem;
  logic [DIV_D-1:0] dsr;
  logic [5:0]       cnt;
  logic [DIV_D:0]   rem_sh;
  logic [DIV_D:0]   trial;
  logic             ge;

  always_comb begin
    rem_sh = {rem[DIV_D-1:0], quotient[DIV_N-1]};
    trial  = rem_sh - {1'b0, dsr};
    ge     = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? trial : rem_sh;
        quotient <= {quotient[DIV_N-2:0], ge};
        cnt      <= cnt + 6'd1;
        if (cnt == 6'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/abs_mac.sv
// Shared signed multiply-accumulate unit with rounding preload.
module abs_mac (
  input  logic                             clk,
  input  abs_pkg::mac_ctl_t                ctl,
  input  logic signed [17:0]               a,
  input  logic signed [16:0]               b,
  output logic signed [abs_pkg::ACC_W-1:0] acc
);
  import abs_pkg::*;

  logic signed [ACC_W-1:0] base;
  logic signed [34:0]      prod;

  always_comb begin
    prod = a * b;
    case (ctl.rnd)
      RND_Q15: base = ACC_W'(16384);
      RND_Q16: base = ACC_W'(32768);
      default: base = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= (ctl.clr ? base : acc) + ACC_W'(prod);
    end
  end
endmodule

>>> hdl/abs_slip_controller_unit.sv
// Top level of the four-wheel anti-lock slip controller.
//
// One input item is one control tick: four wheel speeds (1/64 km/h) and
// four sensor-valid flags. It is accepted when in_valid is high and
// in_stall is low. One result item follows per tick: four pressure
// commands, four wheel modes and the any_active flag, handed over when
// out_valid is high and out_stall is low.
// The block works on one tick at a time. A small sequencer drives one
// restoring divider and one multiply-accumulate unit. The reference
// speed estimate is skipped when no wheel is in range. Each enabled wheel
// with a valid sensor runs the full sequence, with the slip division only
// when it is needed; any other wheel is skipped.
// in_stall is high while a tick is in work. The result sits in an output
// register; a stalled receiver holds the block only when the next tick is
// finished before the last is taken.
// Configuration is written through cfg_valid/cfg_ready, always ready,
// and must only be written while the block is idle. A synchronous reset
// restores the register defaults and sets every wheel inactive at full
// pressure.
`include "abs_slip_controller_unit_assert.svh"
module abs_slip_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] speed_0,
  input  logic [15:0] speed_1,
  input  logic [15:0] speed_2,
  input  logic [15:0] speed_3,
  input  logic        valid_0,
  input  logic        valid_1,
  input  logic        valid_2,
  input  logic        valid_3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pressure_0,
  output logic [15:0] pressure_1,
  output logic [15:0] pressure_2,
  output logic [15:0] pressure_3,
  output logic [1:0]  mode_0,
  output logic [1:0]  mode_1,
  output logic [1:0]  mode_2,
  output logic [1:0]  mode_3,
  output logic        any_active,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import abs_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MEAN  = 5'd1;
  localparam logic [4:0] S_MEANW = 5'd2;
  localparam logic [4:0] S_REF1  = 5'd3;
  localparam logic [4:0] S_REF2  = 5'd4;
  localparam logic [4:0] S_REF3  = 5'd5;
  localparam logic [4:0] S_WCHK  = 5'd6;
  localparam logic [4:0] S_ACC1  = 5'd7;
  localparam logic [4:0] S_ACC2  = 5'd8;
  localparam logic [4:0] S_ACC3  = 5'd9;
  localparam logic [4:0] S_FIL1  = 5'd10;
  localparam logic [4:0] S_FIL2  = 5'd11;
  localparam logic [4:0] S_FIL3  = 5'd12;
  localparam logic [4:0] S_SLIPW = 5'd13;
  localparam logic [4:0] S_MACH1 = 5'd14;
  localparam logic [4:0] S_MACH2 = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;
  localparam logic [4:0] S_ACC4  = 5'd17;

  // Configuration registers.
  logic [15:0] slip_engage, slip_release, reduction_rate, increase_rate;
  logic [15:0] engage_speed_min, max_wheel_speed;
  logic signed [15:0] recovery_accel;
  logic [3:0]  wheel_enable_mask;

  // Controller state.
  logic [15:0] ref_speed;
  logic [15:0] vs;
  logic [15:0] prev_speed [NW];
  logic signed [15:0] filt_accel [NW];
  logic [1:0]  wheel_mode [NW];
  logic [1:0]  pressure_phase [NW];
  logic [15:0] pressure_level [NW];

  // Tick in work.
  logic [4:0]  state;
  logic [WI_W-1:0] w;
  logic [15:0] sp [NW];
  logic [NW-1:0] vld;
  logic        any;
  logic [15:0] inst;
  logic signed [15:0] raw_a;
  logic [15:0] slip;
  logic        neg;
  logic [15:0] q9;

  // Shared units.
  logic              div_start, div_busy, div_done;
  logic [DIV_N-1:0]  div_dividend, div_q;
  logic [DIV_D-1:0]  div_divisor;
  mac_ctl_t          mac_ctl;
  logic signed [17:0] mac_a;
  logic signed [16:0] mac_b;
  logic signed [ACC_W-1:0] acc;

  abs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .quotient(div_q), .busy(div_busy), .done(div_done)
  );

  abs_mac u_mac (.clk(clk), .ctl(mac_ctl), .a(mac_a), .b(mac_b), .acc(acc));

  // Statistics of the in-range speeds for the reference estimate.
  logic [15:0] mx;
  logic [17:0] sum;
  logic [2:0]  cnt;
  always_comb begin
    mx  = '0;
    sum = '0;
    cnt = '0;
    for (int i = 0; i < NW; i++) begin
      if (sp[i] <= max_wheel_speed) begin
        if (sp[i] > mx) mx = sp[i];
        sum = sum + 18'(sp[i]);
        cnt = cnt + 3'd1;
      end
    end
  end

  // Values of the wheel under work.
  logic [15:0] spw;
  logic        fault, slip_ok, last_w, wheel_on;
  logic signed [17:0] diff;
  logic [15:0] dmag;
  logic [31:0] mag;
  logic [16:0] sc_raw;
  logic [15:0] sc;
  logic signed [15:0] acc_w;
  logic [1:0]  m_next, ph_next;
  logic [15:0] p_next;
  always_comb begin
    spw      = sp[w];
    fault    = spw > max_wheel_speed;
    slip_ok  = (vs >= 16'd64) && (spw < vs);
    last_w   = w == WI_W'(NW - 1);
    wheel_on = wheel_enable_mask[w] && vld[w];
    diff     = $signed({2'b00, spw}) - $signed({2'b00, prev_speed[w]});
    dmag     = diff[17] ? 16'(-diff) : diff[15:0];
    mag      = acc[31:0];
    sc_raw   = acc[31:15];
    sc       = (sc_raw > 17'(FULL_PRESSURE)) ? FULL_PRESSURE : sc_raw[15:0];
    acc_w    = filt_accel[w];
  end

  // Activation and pressure phase machines of the wheel under work.
  always_comb begin
    m_next  = wheel_mode[w];
    ph_next = pressure_phase[w];
    p_next  = pressure_level[w];
    case (wheel_mode[w])
      MODE_INACTIVE: begin
        if (vs > engage_speed_min && slip > slip_engage && !fault) begin
          m_next  = MODE_ACTIVE;
          ph_next = PH_REDUCE;
        end
      end
      MODE_MONITOR: begin
        if (slip > slip_engage) begin
          m_next  = MODE_ACTIVE;
          ph_next = PH_REDUCE;
        end else if (vs < engage_speed_min) begin
          m_next = MODE_INACTIVE;
        end
      end
      MODE_ACTIVE: begin
        case (pressure_phase[w])
          PH_REDUCE: begin
            p_next = sc;
            if (acc_w > recovery_accel) ph_next = PH_HOLD;
          end
          PH_HOLD: begin
            if (slip < slip_release) ph_next = PH_INCREASE;
            else if (slip > slip_engage) ph_next = PH_REDUCE;
          end
          PH_INCREASE: begin
            p_next = sc;
            if (slip > slip_engage) ph_next = PH_REDUCE;
          end
          default: p_next = FULL_PRESSURE;
        endcase
        if (slip < slip_release && acc_w > -16'sd256) begin
          m_next  = MODE_MONITOR;
          ph_next = PH_NORMAL;
        end
        if (fault) m_next = MODE_FAULT;
      end
      default: begin
        p_next = FULL_PRESSURE;
        if (!fault) m_next = MODE_INACTIVE;
      end
    endcase
  end

  // Sequencer drive of the shared units.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mac_ctl      = '{en: 1'b0, clr: 1'b0, rnd: RND_NONE};
    mac_a        = '0;
    mac_b        = '0;
    case (state)
      S_MEAN: begin
        div_start    = cnt != 3'd0;
        div_dividend = 32'(sum);
        div_divisor  = 16'(cnt);
      end
      S_REF1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: RND_Q16};
        mac_a   = $signed({2'b00, inst});
        mac_b   = 17'sd6554;
      end
      S_REF2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, rnd: RND_NONE};
        mac_a   = $signed({2'b00, ref_speed});
        mac_b   = 17'sd58982;
      end
      // The ninth of the speed step first, then the whole part.
      S_ACC1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: RND_NONE};
        mac_a   = $signed({2'b00, dmag});
        mac_b   = 17'(RECIP9);
      end
      S_ACC2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: RND_NONE};
        mac_a   = $signed({2'b00, dmag});
        mac_b   = 17'(ACC_WHOLE);
      end
      S_ACC3: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, rnd: RND_NONE};
        mac_a   = $signed({2'b00, q9});
        mac_b   = 17'sd1;
      end
      S_FIL1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: RND_Q16};
        mac_a   = 18'(raw_a);
        mac_b   = 17'sd13107;
      end
      S_FIL2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, rnd: RND_NONE};
        mac_a   = 18'(acc_w);
        mac_b   = 17'sd52429;
      end
      S_FIL3: begin
        div_start    = slip_ok;
        div_dividend = {vs - spw, 16'h0000};
        div_divisor  = vs;
      end
      S_MACH1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: RND_Q15};
        mac_a   = $signed({2'b00, pressure_level[w]});
        mac_b   = $signed({1'b0, (pressure_phase[w] == PH_REDUCE) ?
                                 reduction_rate : increase_rate});
      end
      default: ;
    endcase
  end

  assign in_stall  = state != S_IDLE;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      slip_engage       <= 16'd13107;
      slip_release      <= 16'd6554;
      reduction_rate    <= 16'd29491;
      increase_rate     <= 16'd34406;
      engage_speed_min  <= 16'd320;
      recovery_accel    <= 16'sd0;
      max_wheel_speed   <= 16'd19200;
      wheel_enable_mask <= 4'hF;
      ref_speed         <= '0;
      w                 <= '0;
      for (int i = 0; i < NW; i++) begin
        prev_speed[i]     <= '0;
        filt_accel[i]     <= '0;
        wheel_mode[i]     <= MODE_INACTIVE;
        pressure_phase[i] <= PH_NORMAL;
        pressure_level[i] <= FULL_PRESSURE;
      end
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_SLIP_THR:  slip_engage       <= cfg_data;
          REG_SLIP_TGT:  slip_release      <= cfg_data;
          REG_RED_RATE:  reduction_rate    <= cfg_data;
          REG_INC_RATE:  increase_rate     <= cfg_data;
          REG_MIN_SPEED: engage_speed_min  <= cfg_data;
          REG_REC_ACCEL: recovery_accel    <= $signed(cfg_data);
          REG_MAX_SPEED: max_wheel_speed   <= cfg_data;
          REG_EN_MASK:   wheel_enable_mask <= cfg_data[3:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sp[0] <= speed_0;
            sp[1] <= speed_1;
            sp[2] <= speed_2;
            sp[3] <= speed_3;
            vld   <= {valid_3, valid_2, valid_1, valid_0};
            any   <= 1'b0;
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          w <= '0;
          if (cnt != 3'd0) begin
            state <= S_MEANW;
          end else begin
            vs    <= '0;
            state <= S_WCHK;
          end
        end
        S_MEANW: begin
          if (div_done) begin
            inst  <= 16'((17'(mx) + 17'(div_q[15:0])) >> 1);
            state <= S_REF1;
          end
        end
        S_REF1: state <= S_REF2;
        S_REF2: state <= S_REF3;
        S_REF3: begin
          ref_speed <= acc[31:16];
          vs        <= acc[31:16];
          state     <= S_WCHK;
        end
        S_WCHK: begin
          if (wheel_on) begin
            state <= S_ACC1;
          end else if (last_w) begin
            state <= S_DONE;
          end else begin
            w <= w + 1'b1;
          end
        end
        S_ACC1: begin
          neg   <= diff < 0;
          state <= S_ACC2;
        end
        S_ACC2: begin
          q9    <= 16'(acc[31:RECIP9_SH]);
          state <= S_ACC3;
        end
        S_ACC3: state <= S_ACC4;
        // The magnitude is truncated, so the sign applied after it rounds
        // toward zero.
        S_ACC4: begin
          if (!neg) raw_a <= (mag > 32'd32767) ? 16'sd32767 : $signed(mag[15:0]);
          else raw_a <= (mag > 32'd32768) ? 16'sh8000 : $signed(16'(-mag));
          state <= S_FIL1;
        end
        S_FIL1: state <= S_FIL2;
        S_FIL2: state <= S_FIL3;
        S_FIL3: begin
          filt_accel[w] <= $signed(acc[31:16]);
          if (slip_ok) begin
            state <= S_SLIPW;
          end else begin
            slip  <= '0;
            state <= S_MACH1;
          end
        end
        S_SLIPW: begin
          if (div_done) begin
            slip  <= (div_q > 32'd65535) ? 16'hFFFF : div_q[15:0];
            state <= S_MACH1;
          end
        end
        S_MACH1: state <= S_MACH2;
        S_MACH2: begin
          wheel_mode[w]     <= m_next;
          pressure_phase[w] <= ph_next;
          pressure_level[w] <= p_next;
          prev_speed[w]     <= spw;
          if (m_next == MODE_ACTIVE) any <= 1'b1;
          if (last_w) begin
            state <= S_DONE;
          end else begin
            w     <= w + 1'b1;
            state <= S_WCHK;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            pressure_0 <= pressure_level[0];
            pressure_1 <= pressure_level[1];
            pressure_2 <= pressure_level[2];
            pressure_3 <= pressure_level[3];
            mode_0     <= wheel_mode[0];
            mode_1     <= wheel_mode[1];
            mode_2     <= wheel_mode[2];
            mode_3     <= wheel_mode[3];
            any_active <= any;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ABS_CHK_NOW(a_div_idle, state == S_IDLE || state == S_DONE, !div_busy)
  `ABS_CHK_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `ABS_CHK_NEXT(a_done_shows, state == S_DONE && !(out_valid && out_stall), out_valid)
  `ABS_CHK_NOW(a_press_bound, out_valid, pressure_0 <= FULL_PRESSURE)
endmodule
